[sv/wes_pkg.sv]
package wes_pkg;

	localparam int NX_MAX_DEF = 1024;
	localparam int DATA_W     = 32;
	localparam int COEF_W     = 16;
	localparam int WIDTH_W    = 11;
	localparam int ROW_W      = 16;
	localparam int COL_W      = 10;
	localparam int CFG_IDX_W  = 3;

	localparam logic [CFG_IDX_W-1:0] REG_COEF_X      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_Y      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TOP_WALL    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_WALL = 3'd5;

	localparam logic OP_POINT = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	// Values seen by the item at the head of the line buffers.
	typedef struct packed {
		logic signed [DATA_W-1:0] cur;
		logic signed [DATA_W-1:0] nxt;
		logic signed [DATA_W-1:0] held;
		logic signed [DATA_W-1:0] upper;
		logic signed [DATA_W-1:0] prev;
	} wes_window_t;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             last;
	} wes_tag_t;

endpackage

[sv/wave_equation_stencil_step.sv]
// Streaming step of the 2-D wave equation over one band of grid rows.
// Configure coef_x, coef_y, row_width, row_count and the two wall flags
// through the cfg channel (always ready) before the band starts. Grid
// points then enter on the in channel in raster order with opcode point;
// each row is computed while the next one streams in, so results run one
// row behind. With a wall at the bottom the last row is drained by flush
// items, one per column.
// One item is taken in every cycle while the receiver does not stall.
// A result is registered through one stage for the neighbour
// differences, one for the products and one for the sum and saturation.
// The line buffers are read ahead and add no latency.
// When the receiver stalls, the whole pipeline holds and in_ready falls
// in the same cycle; nothing is lost or repeated.
// Reset clears the counters, the pipeline valids and the registers to
// their defaults. The line buffers need no clearing: the first row only
// fills them. After the last item of the band, the final point or, with
// a wall at the bottom, the final flush, items are dropped until the next reset.
module wave_equation_stencil_step import wes_pkg::*; #(
	parameter int NX_MAX = NX_MAX_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [COEF_W-1:0]        cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     opcode,
	input  logic signed [DATA_W-1:0] u_value,
	input  logic signed [DATA_W-1:0] prev_value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] new_value,
	output logic [ROW_W-1:0]         out_row,
	output logic [COL_W-1:0]         out_col,
	output logic                     last_point
);

	localparam int CW = $clog2(NX_MAX);
	localparam int WW = CW + 1;

	logic [COEF_W-1:0]  coef_x_q, coef_y_q;
	logic [WIDTH_W-1:0] row_width_q;
	logic [ROW_W-1:0]   row_count_q;
	logic               top_wall_q, bottom_wall_q;

	logic [ROW_W-1:0] row_q;
	logic [CW-1:0]    col_q;
	logic             done_q;

	logic [WW-1:0]    w_eff, c1;
	logic [WW:0]      c2;
	logic [ROW_W-1:0] rc, m;
	logic             edge_r, en, accept, adv, emit, is_flush, last;
	logic [CW-1:0]    mid_addr, up_addr;
	logic [ROW_W:0]   r1;

	wes_window_t              win;
	wes_tag_t                 tag_in, tag_out;
	logic signed [DATA_W-1:0] op_l, op_r, op_a, op_b;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_x_q      <= '0;
			coef_y_q      <= '0;
			row_width_q   <= WIDTH_W'(3);
			row_count_q   <= ROW_W'(2);
			top_wall_q    <= 1'b1;
			bottom_wall_q <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_COEF_X:      coef_x_q      <= cfg_data;
				REG_COEF_Y:      coef_y_q      <= cfg_data;
				REG_ROW_WIDTH:   row_width_q   <= cfg_data[WIDTH_W-1:0];
				REG_ROW_COUNT:   row_count_q   <= cfg_data;
				REG_TOP_WALL:    top_wall_q    <= cfg_data[0];
				REG_BOTTOM_WALL: bottom_wall_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (row_width_q < WIDTH_W'(3))
			w_eff = WW'(3);
		else if (int'(row_width_q) > NX_MAX)
			w_eff = WW'(NX_MAX);
		else
			w_eff = WW'(row_width_q);
	end

	assign rc       = (row_count_q < ROW_W'(2)) ? ROW_W'(2) : row_count_q;
	assign c1       = WW'(col_q) + WW'(1);
	assign c2       = (WW + 1)'(col_q) + (WW + 1)'(2);
	assign edge_r   = c1 >= w_eff;
	assign r1       = (ROW_W + 1)'(row_q) + (ROW_W + 1)'(1);
	assign is_flush = opcode == OP_FLUSH;

	assign mid_addr = (c2 < (WW + 1)'(w_eff)) ? CW'(c2) : CW'(c2 - (WW + 1)'(w_eff));
	assign up_addr  = edge_r ? '0 : CW'(c1);

	assign en       = !out_valid || out_ready;
	assign in_ready = en;
	assign accept   = in_valid && en;

	// Decide what an item does: points beyond the band, early flushes,
	// flushes without a bottom wall and items after the band leave everything untouched.
	always_comb begin
		adv  = 1'b0;
		emit = 1'b0;
		last = 1'b0;
		m    = row_q - ROW_W'(1);
		if (!done_q) begin
			if (!is_flush) begin
				if (row_q < rc) begin
					adv  = 1'b1;
					emit = row_q != '0 && (m != '0 || top_wall_q);
					last = r1 == (ROW_W + 1)'(rc) && !bottom_wall_q && edge_r;
				end
			end else if (row_q >= rc && bottom_wall_q) begin
				adv  = 1'b1;
				emit = 1'b1;
				m    = rc - ROW_W'(1);
				last = edge_r;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			done_q <= 1'b0;
		end else if (accept && adv) begin
			if (edge_r) begin
				col_q <= '0;
				if (is_flush) begin
					done_q <= 1'b1;
				end else begin
					row_q <= ROW_W'(r1);
					if (r1 >= (ROW_W + 1)'(rc) && !bottom_wall_q)
						done_q <= 1'b1;
				end
			end else begin
				col_q <= CW'(c1);
			end
		end
	end

	wes_linebuf #(.NX_MAX(NX_MAX), .CW(CW)) u_linebuf (
		.clk      (clk),
		.adv      (accept && adv),
		.wr       (!is_flush),
		.col      (col_q),
		.mid_addr (mid_addr),
		.up_addr  (up_addr),
		.u_in     (u_value),
		.p_in     (prev_value),
		.win      (win)
	);

	// Mirror the missing neighbours at the edges and walls.
	always_comb begin
		op_l = (col_q == '0) ? win.nxt : win.held;
		op_r = edge_r ? op_l : win.nxt;
		if (is_flush) begin
			op_a = win.upper;
			op_b = win.upper;
		end else begin
			op_a = (m == '0) ? u_value : win.upper;
			op_b = u_value;
		end
	end

	assign tag_in.row  = m;
	assign tag_in.col  = COL_W'(col_q);
	assign tag_in.last = last;

	wes_stencil u_stencil (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.v_in    (accept && adv && emit),
		.tag_in  (tag_in),
		.u       (win.cur),
		.pv      (win.prev),
		.l       (op_l),
		.r       (op_r),
		.a       (op_a),
		.b       (op_b),
		.coef_x  (coef_x_q),
		.coef_y  (coef_y_q),
		.v_out   (out_valid),
		.tag_out (tag_out),
		.value   (new_value)
	);

	assign out_row    = tag_out.row;
	assign out_col    = tag_out.col;
	assign last_point = tag_out.last;

endmodule

[sv/wes_linebuf.sv]
module wes_linebuf import wes_pkg::*; #(
	parameter int NX_MAX = NX_MAX_DEF,
	parameter int CW     = $clog2(NX_MAX)
) (
	input  logic                     clk,
	input  logic                     adv,
	input  logic                     wr,
	input  logic [CW-1:0]            col,
	input  logic [CW-1:0]            mid_addr,
	input  logic [CW-1:0]            up_addr,
	input  logic signed [DATA_W-1:0] u_in,
	input  logic signed [DATA_W-1:0] p_in,
	output wes_window_t              win
);

	logic signed [DATA_W-1:0] upper_mem [NX_MAX];
	logic signed [DATA_W-1:0] mid_mem   [NX_MAX];
	logic signed [DATA_W-1:0] prev_mem  [NX_MAX];

	logic signed [DATA_W-1:0] rd_q, cur_q, held_q, upr_q, prv_q;

	// Reads run ahead of the column: the middle row two places, the
	// others one place, wrapping into the row now being written.
	always_ff @(posedge clk) begin
		if (adv) begin
			if (wr) begin
				upper_mem[col] <= cur_q;
				mid_mem[col]   <= u_in;
				prev_mem[col]  <= p_in;
			end
			rd_q   <= mid_mem[mid_addr];
			upr_q  <= upper_mem[up_addr];
			prv_q  <= prev_mem[up_addr];
			cur_q  <= rd_q;
			held_q <= cur_q;
		end
	end

	assign win.cur   = cur_q;
	assign win.nxt   = rd_q;
	assign win.held  = held_q;
	assign win.upper = upr_q;
	assign win.prev  = prv_q;

endmodule

[sv/wes_stencil.sv]
module wes_stencil import wes_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     v_in,
	input  wes_tag_t                 tag_in,
	input  logic signed [DATA_W-1:0] u,
	input  logic signed [DATA_W-1:0] pv,
	input  logic signed [DATA_W-1:0] l,
	input  logic signed [DATA_W-1:0] r,
	input  logic signed [DATA_W-1:0] a,
	input  logic signed [DATA_W-1:0] b,
	input  logic [COEF_W-1:0]        coef_x,
	input  logic [COEF_W-1:0]        coef_y,
	output logic                     v_out,
	output wes_tag_t                 tag_out,
	output logic signed [DATA_W-1:0] value
);

	localparam int SW = DATA_W + 3;
	localparam int PW = SW + COEF_W + 1;
	localparam int TW = DATA_W + 6;

	logic                     v_s1, v_s2, v_q;
	wes_tag_t                 tag_s1, tag_s2, tag_q;
	logic signed [SW-1:0]     u2_s1, sx_s1, sy_s1, u2_s2;
	logic signed [DATA_W-1:0] pv_s1, pv_s2, val_q;
	logic signed [PW-1:0]     px_s2, py_s2;
	logic signed [SW-1:0]     u2_w;
	logic signed [TW-1:0]     total;

	assign u2_w = SW'(u) <<< 1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_q  <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
			v_q  <= v_s2;
		end
	end

	// An arithmetic right shift of the product floors it.
	assign total = TW'(u2_s2) + TW'(px_s2 >>> 16) + TW'(py_s2 >>> 16) - TW'(pv_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s1 <= tag_in;
			u2_s1  <= u2_w;
			sx_s1  <= SW'(l) + SW'(r) - u2_w;
			sy_s1  <= SW'(a) + SW'(b) - u2_w;
			pv_s1  <= pv;
			tag_s2 <= tag_s1;
			u2_s2  <= u2_s1;
			pv_s2  <= pv_s1;
			px_s2  <= PW'(sx_s1) * PW'($signed({1'b0, coef_x}));
			py_s2  <= PW'(sy_s1) * PW'($signed({1'b0, coef_y}));
			tag_q  <= tag_s2;
			if (total > TW'(32'sh7fffffff))
				val_q <= 32'sh7fffffff;
			else if (total < -TW'(64'sh80000000))
				val_q <= 32'sh80000000;
			else
				val_q <= DATA_W'(total);
		end
	end

	assign v_out   = v_q;
	assign tag_out = tag_q;
	assign value   = val_q;

endmodule

[tb/sv/testbench.sv]
module testbench;
	import wes_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [DATA_W-1:0] value;
		logic [ROW_W-1:0]         row;
		logic [COL_W-1:0]         col;
		logic                     last;
	} point_result_t;

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [CFG_IDX_W-1:0]     cfg_index;
	logic [COEF_W-1:0]        cfg_data;
	logic                     in_valid;
	logic                     in_ready;
	logic                     opcode;
	logic signed [DATA_W-1:0] u_value;
	logic signed [DATA_W-1:0] prev_value;
	logic                     out_valid;
	logic                     out_ready;
	logic signed [DATA_W-1:0] new_value;
	logic [ROW_W-1:0]         out_row;
	logic [COL_W-1:0]         out_col;
	logic                     last_point;

	wave_equation_stencil_step dut (.*);

	// Shadow copy of the block's registers and line buffers.
	int unsigned              coef_x_q, coef_y_q, row_width_q, row_count_q;
	bit                       top_wall_q, bottom_wall_q;
	logic signed [DATA_W-1:0] upper_buf [NX_MAX_DEF];
	logic signed [DATA_W-1:0] middle_buf [NX_MAX_DEF];
	logic signed [DATA_W-1:0] middle_prev_buf [NX_MAX_DEF];
	logic signed [DATA_W-1:0] held_left_q;
	int unsigned              row_pos, col_pos;
	bit                       band_finished;

	point_result_t pending_points[$];
	int            error_count;
	bit            idle_on;
	bit            stall_on;
	int            stall_left;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic int unsigned active_width();
		if (row_width_q < 3)
			return 3;
		if (row_width_q > NX_MAX_DEF)
			return NX_MAX_DEF;
		return row_width_q;
	endfunction

	function automatic int unsigned active_rows();
		return (row_count_q < 2) ? 2 : row_count_q;
	endfunction

	function automatic logic signed [DATA_W-1:0] wave_update(longint u, longint pv, longint l,
			longint r, longint a, longint b);
		longint u2, t;
		u2 = 2 * u;
		// Arithmetic shift gives the truncation towards minus infinity.
		t = u2 + (((l - u2 + r) * longint'(coef_x_q)) >>> 16)
			+ (((b - u2 + a) * longint'(coef_y_q)) >>> 16) - pv;
		if (t > 64'sd2147483647)
			t = 64'sd2147483647;
		if (t < -64'sd2147483648)
			t = -64'sd2147483648;
		return t[DATA_W-1:0];
	endfunction

	function automatic void advance_stencil(logic op, logic signed [DATA_W-1:0] u_in,
			logic signed [DATA_W-1:0] p_in);
		int unsigned   w, rc, r, c, m;
		bit            at_right;
		point_result_t res;
		logic signed [DATA_W-1:0] l, rt, a;
		w = active_width();
		rc = active_rows();
		r = row_pos;
		c = col_pos;
		at_right = (c + 1 >= w);
		if (band_finished)
			return;
		if (op == OP_POINT) begin
			if (r >= rc)
				return;
			if (r >= 1) begin
				m = r - 1;
				if (m > 0 || top_wall_q) begin
					l = (c == 0) ? middle_buf[1] : held_left_q;
					rt = at_right ? l : middle_buf[c + 1];
					a = (m == 0) ? u_in : upper_buf[c];
					res.value = wave_update(middle_buf[c], middle_prev_buf[c], l, rt, a, u_in);
					res.row = m[ROW_W-1:0];
					res.col = c[COL_W-1:0];
					res.last = (m + 2 == rc) && !bottom_wall_q && at_right;
					pending_points.push_back(res);
				end
			end
			held_left_q = middle_buf[c];
			upper_buf[c] = middle_buf[c];
			middle_buf[c] = u_in;
			middle_prev_buf[c] = p_in;
			if (at_right) begin
				col_pos = 0;
				row_pos = r + 1;
				if (row_pos >= rc && !bottom_wall_q)
					band_finished = 1'b1;
			end else begin
				col_pos = c + 1;
			end
			return;
		end
		if (r < rc || !bottom_wall_q)
			return;
		m = rc - 1;
		l = (c == 0) ? middle_buf[1] : held_left_q;
		rt = at_right ? l : middle_buf[c + 1];
		res.value = wave_update(middle_buf[c], middle_prev_buf[c], l, rt, upper_buf[c],
			upper_buf[c]);
		res.row = m[ROW_W-1:0];
		res.col = c[COL_W-1:0];
		res.last = at_right;
		pending_points.push_back(res);
		held_left_q = middle_buf[c];
		if (at_right) begin
			band_finished = 1'b1;
			col_pos = 0;
		end else begin
			col_pos = c + 1;
		end
	endfunction

	function automatic logic signed [DATA_W-1:0] field_value();
		case ($urandom_range(0, 9))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return '0;
			3, 4, 5: return $urandom;
			default: return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
		endcase
	endfunction

	task automatic send_item(logic op, logic signed [DATA_W-1:0] u,
			logic signed [DATA_W-1:0] p);
		int gap;
		gap = 0;
		if (idle_on) begin
			case ($urandom_range(0, 19))
				0: gap = $urandom_range(10, 30);
				1, 2, 3, 4, 5: gap = $urandom_range(1, 3);
				default: gap = 0;
			endcase
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		u_value <= u;
		prev_value <= p;
		do
			@(posedge clk);
		while (!in_ready);
		advance_stencil(op, u, p);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data[COEF_W-1:0];
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_COEF_X: coef_x_q = data & 16'hffff;
			REG_COEF_Y: coef_y_q = data & 16'hffff;
			REG_ROW_WIDTH: row_width_q = data & 11'h7ff;
			REG_ROW_COUNT: row_count_q = data & 16'hffff;
			REG_TOP_WALL: top_wall_q = data[0];
			REG_BOTTOM_WALL: bottom_wall_q = data[0];
			default: ;
		endcase
	endtask

	// Waits until every expected result is out and the pipeline has emptied.
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_points.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic stream_rows(int rows);
		repeat (rows * active_width())
			send_item(OP_POINT, field_value(), field_value());
	endtask

	task automatic test_wide_band();
		idle_on = 1'b1;
		stall_on = 1'b1;
		write_reg(REG_COEF_X, $urandom_range(0, 16'hffff));
		write_reg(REG_COEF_Y, $urandom_range(0, 16'hffff));
		write_reg(REG_ROW_WIDTH, 120);
		write_reg(REG_ROW_COUNT, 16'hffff);
		write_reg(REG_TOP_WALL, 0);
		write_reg(REG_TOP_WALL, 1);
		write_reg(REG_BOTTOM_WALL, 1);
		stream_rows(1);
		// A flush before the last row has streamed in is dropped.
		send_item(OP_FLUSH, field_value(), field_value());
		stream_rows(1);
		settle();
	endtask

	task automatic test_extremes();
		idle_on = 1'b0;
		stall_on = 1'b0;
		write_reg(REG_ROW_WIDTH, 0);
		write_reg(REG_COEF_X, 16'hffff);
		write_reg(REG_COEF_Y, 16'hffff);
		send_item(OP_POINT, 32'sh7fffffff, 32'sh80000000);
		send_item(OP_POINT, 32'sh80000000, 32'sh7fffffff);
		send_item(OP_POINT, 32'sh7fffffff, '0);
		send_item(OP_POINT, 32'sh80000000, 32'sh80000000);
		send_item(OP_FLUSH, 32'sh7fffffff, 32'sh7fffffff);
		send_item(OP_POINT, 32'sh7fffffff, 32'sh7fffffff);
		send_item(OP_POINT, 32'sh80000000, 32'sh80000000);
		send_item(OP_POINT, '0, 32'sh7fffffff);
		send_item(OP_POINT, 32'sh7fffffff, '0);
		send_item(OP_POINT, 32'sh80000000, 32'sh7fffffff);
		settle();
		write_reg(REG_COEF_X, 0);
		write_reg(REG_COEF_Y, 0);
		send_item(OP_POINT, 32'sh80000000, 32'sh7fffffff);
		send_item(OP_POINT, 32'sh7fffffff, 32'sh80000000);
		send_item(OP_POINT, '0, '0);
		settle();
	endtask

	task automatic test_coefficient_sweep();
		int unsigned cx, cy, w;
		for (int s = 0; s < 18; s++) begin
			case (s % 4)
				0: begin cx = 0; cy = 16'hffff; end
				1: begin cx = 16'hffff; cy = 0; end
				2: begin cx = $urandom_range(0, 16'hffff); cy = $urandom_range(0, 16'hffff); end
				default: begin cx = $urandom_range(0, 4096); cy = $urandom_range(0, 4096); end
			endcase
			case ($urandom_range(0, 9))
				0: w = $urandom_range(0, 2);
				1: w = $urandom_range(13, 120);
				default: w = $urandom_range(3, 12);
			endcase
			write_reg(REG_COEF_X, cx);
			write_reg(REG_COEF_Y, cy);
			write_reg(REG_ROW_WIDTH, w);
			write_reg(REG_ROW_COUNT, $urandom_range(1000, 16'hffff));
			write_reg(REG_TOP_WALL, $urandom_range(0, 1));
			write_reg(REG_BOTTOM_WALL, $urandom_range(0, 1));
			idle_on = ($urandom_range(0, 3) != 0);
			stall_on = ($urandom_range(0, 3) != 0);
			stream_rows($urandom_range(3, 5));
			// Flushes are dropped while rows are still to come.
			send_item(OP_FLUSH, field_value(), field_value());
			settle();
		end
		write_reg(REG_BOTTOM_WALL, 1);
	endtask

	task automatic test_bottom_wall_drain();
		idle_on = 1'b1;
		stall_on = 1'b1;
		write_reg(REG_ROW_WIDTH, $urandom_range(3, 9));
		write_reg(REG_ROW_COUNT, row_pos + 1);
		stream_rows(1);
		// Points after the last row are dropped.
		repeat (3)
			send_item(OP_POINT, field_value(), field_value());
		repeat (active_width() + 2)
			send_item(OP_FLUSH, field_value(), field_value());
		send_item(OP_POINT, field_value(), field_value());
		settle();
	endtask

	always @(posedge clk) begin
		if (!stall_on) begin
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else begin
			case ($urandom_range(0, 29))
				0: begin stall_left <= $urandom_range(10, 40); out_ready <= 1'b0; end
				1, 2, 3, 4, 5, 6: out_ready <= 1'b0;
				default: out_ready <= 1'b1;
			endcase
		end
	end

	always @(posedge clk) begin
		point_result_t exp_res;
		if (arst_n && out_valid && out_ready) begin
			if (pending_points.size() == 0) begin
				$display("%0t: unexpected result value %h row %0d col %0d last %b",
					$time, new_value, out_row, out_col, last_point);
				error_count++;
			end else begin
				exp_res = pending_points.pop_front();
				if (new_value !== exp_res.value) begin
					$display("%0t: new_value expected %h actual %h", $time, exp_res.value,
						new_value);
					error_count++;
				end
				if (out_row !== exp_res.row) begin
					$display("%0t: out_row expected %0d actual %0d", $time, exp_res.row, out_row);
					error_count++;
				end
				if (out_col !== exp_res.col) begin
					$display("%0t: out_col expected %0d actual %0d", $time, exp_res.col, out_col);
					error_count++;
				end
				if (last_point !== exp_res.last) begin
					$display("%0t: last_point expected %b actual %b", $time, exp_res.last,
						last_point);
					error_count++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		opcode = OP_POINT;
		u_value = '0;
		prev_value = '0;
		out_ready = 1'b1;
		stall_on = 1'b0;
		stall_left = 0;
		idle_on = 1'b0;
		error_count = 0;
		coef_x_q = 0;
		coef_y_q = 0;
		row_width_q = 3;
		row_count_q = 2;
		top_wall_q = 1'b1;
		bottom_wall_q = 1'b1;
		row_pos = 0;
		col_pos = 0;
		band_finished = 1'b0;
		held_left_q = '0;
		for (int i = 0; i < NX_MAX_DEF; i++) begin
			upper_buf[i] = '0;
			middle_buf[i] = '0;
			middle_prev_buf[i] = '0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_wide_band();
		test_extremes();
		test_coefficient_sweep();
		test_bottom_wall_drain();
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#20ms;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
